// File: src/hpi_pkg.sv
// Shared types, register codes and averaging functions for the half-pel interpolator.
`timescale 1ns / 1ps

package hpi_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int QUADS     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND  = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd2048;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd2048;

    // slot bit 0 set: quad sits in the current column; bit 1 set: in the current row
    localparam logic [1:0] SLOT_DIAG  = 2'd0;
    localparam logic [1:0] SLOT_RIGHT = 2'd1;
    localparam logic [1:0] SLOT_BELOW = 2'd2;
    localparam logic [1:0] SLOT_FRAME = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] br;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] tl;
    } t_quad;

    typedef struct packed {
        logic [QUADS-1:0]        mask;
        t_quad [QUADS-1:0]       quads;
    } t_load;

    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic             rc);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1) - {{PIX_W{1'b0}}, rc};
        return s[PIX_W:1];
    endfunction

    function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c,
                                              input logic [PIX_W-1:0] d,
                                              input logic             rc);
        logic [PIX_W+1:0] s;
        s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d} + (PIX_W+2)'(2)
            - {{(PIX_W+1){1'b0}}, rc};
        return s[PIX_W+1:2];
    endfunction

endpackage

// File: src/hpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/hpi_seq.sv
// Output stage: holds the quads of one pixel and issues them one word per cycle while the receiver is ready.
`timescale 1ns / 1ps

module hpi_seq
    import hpi_pkg::*;
#(
    parameter int CW = 11,
    parameter int RW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_load         i_ld,
    input  logic [CW-1:0] i_col,
    input  logic [RW-1:0] i_row,
    output logic          o_can_load,
    output logic          o_valid,
    input  logic          i_ready,
    output t_quad         o_quad,
    output logic [CW-1:0] o_col,
    output logic [RW-1:0] o_row,
    output logic          o_last,
    output logic          o_frame
);

    logic [QUADS-1:0] r_mask;
    t_quad            r_quad [QUADS];
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [1:0]       sel;
    logic [QUADS-1:0] rest;
    logic             taken;

    always_comb begin
        priority if (r_mask[0]) begin
            sel = SLOT_DIAG;
        end else if (r_mask[1]) begin
            sel = SLOT_RIGHT;
        end else if (r_mask[2]) begin
            sel = SLOT_BELOW;
        end else begin
            sel = SLOT_FRAME;
        end
    end

    assign rest       = r_mask & ~(QUADS'(1) << sel);
    assign o_valid    = |r_mask;
    assign o_last     = (rest == '0);
    assign o_frame    = (sel == SLOT_FRAME);
    assign taken      = o_valid && i_ready;
    assign o_can_load = !o_valid || (taken && o_last);
    assign o_quad     = r_quad[sel];
    assign o_col      = sel[0] ? r_col : r_col - CW'(1);
    assign o_row      = sel[1] ? r_row : r_row - RW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_ld.mask;
        end else if (taken) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < QUADS; i++) begin
                r_quad[i] <= i_ld.quads[i];
            end
            r_col <= i_col;
            r_row <= i_row;
        end
    end

endmodule

// File: src/half_pel_image_interpolator_top.sv
// Top level of the half-pel interpolator: counters, line store, quad build, output stage.
// A quad is built from the input register and leaves from the output stage's quad registers.
// Throughput: one pixel per cycle while the output accepts each word; a pixel completing
// k quads (last column or last row, k up to 4) holds the input until the single output port takes them.
// Reset: synchronous, active low; clears counters, held pixels, pipeline valids and
// loads the default registers. The line store is not cleared.
`timescale 1ns / 1ps

module half_pel_image_interpolator_top
    import hpi_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [7:0] pixel
    input  logic [PIX_W-1:0]      i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [7:0] quad_top_left, [15:8] quad_top_right, [23:16] quad_bottom_left,
    // [31:24] quad_bottom_right, then quad_column, quad_row, zero fill
    output logic [((4*PIX_W+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+7)/8)*8-1:0] o_m_axis_tdata,
    // last_of_run
    output logic                  o_m_axis_tlast,
    // [0] frame_done
    output logic                  o_m_axis_tuser
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int OUT_W = ((4*PIX_W + CW + RW + 7) / 8) * 8;
    localparam int XW    = 16;

    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic             r_round;

    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [XW-1:0]    w_x;
    logic [XW-1:0]    h_x;
    logic             in_last_col;
    logic             in_last_row;

    logic             r_s1_v;
    logic [PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]    r_s1_col;
    logic [RW-1:0]    r_s1_row;
    logic             r_s1_lc;
    logic             r_s1_lr;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_above_left;
    logic [PIX_W-1:0] above;

    logic             accept;
    logic             s1_adv;
    logic             seq_can_load;
    logic             has_row;
    t_load            ld;
    t_quad            out_quad;
    logic [CW-1:0]    out_col;
    logic [RW-1:0]    out_row;
    logic [PIX_W-1:0] v_above;
    logic [PIX_W-1:0] v_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
            r_round      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_ROUND:  r_round      <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        w_x = XW'(r_cfg_width);
        if (w_x < XW'(2)) begin
            w_x = XW'(2);
        end else if (w_x > XW'(MAX_WIDTH)) begin
            w_x = XW'(MAX_WIDTH);
        end
        h_x = XW'(r_cfg_height);
        if (h_x < XW'(2)) begin
            h_x = XW'(2);
        end else if (h_x > XW'(MAX_HEIGHT)) begin
            h_x = XW'(MAX_HEIGHT);
        end
    end

    assign in_last_col = XW'(r_col) >= (w_x - XW'(1));
    assign in_last_row = XW'(r_row) >= (h_x - XW'(1));

    assign has_row         = (r_s1_row != '0);

    assign s1_adv          = r_s1_v && ((ld.mask == '0) || seq_can_load);
    assign o_s_axis_tready = !r_s1_v || s1_adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_s1_v       <= 1'b0;
            r_left       <= '0;
            r_above_left <= '0;
        end else begin
            if (accept) begin
                if (in_last_col) begin
                    r_col <= '0;
                    r_row <= in_last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_left       <= r_s1_pix;
                r_above_left <= above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= i_s_axis_tdata;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_lc  <= in_last_col;
            r_s1_lr  <= in_last_row;
        end
    end

    hpi_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (above)
    );

    assign v_above = avg2(above, r_s1_pix, r_round);
    assign v_left  = avg2(r_left, r_s1_pix, r_round);

    always_comb begin
        ld.mask[0]     = has_row && (r_s1_col != '0);
        ld.mask[1]     = has_row && r_s1_lc;
        ld.mask[2]     = has_row && r_s1_lr && (r_s1_col != '0);
        ld.mask[3]     = has_row && r_s1_lr && r_s1_lc;
        ld.quads[0].tl = r_above_left;
        ld.quads[0].tr = avg2(r_above_left, above, r_round);
        ld.quads[0].bl = avg2(r_above_left, r_left, r_round);
        ld.quads[0].br = avg4(r_above_left, above, r_left, r_s1_pix, r_round);
        ld.quads[1].tl = above;
        ld.quads[1].tr = above;
        ld.quads[1].bl = v_above;
        ld.quads[1].br = v_above;
        ld.quads[2].tl = r_left;
        ld.quads[2].tr = v_left;
        ld.quads[2].bl = r_left;
        ld.quads[2].br = v_left;
        ld.quads[3].tl = r_s1_pix;
        ld.quads[3].tr = r_s1_pix;
        ld.quads[3].bl = r_s1_pix;
        ld.quads[3].br = r_s1_pix;
    end

    hpi_seq #(
        .CW (CW),
        .RW (RW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_adv && (ld.mask != '0)),
        .i_ld       (ld),
        .i_col      (r_s1_col),
        .i_row      (r_s1_row),
        .o_can_load (seq_can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_quad     (out_quad),
        .o_col      (out_col),
        .o_row      (out_row),
        .o_last     (o_m_axis_tlast),
        .o_frame    (o_m_axis_tuser)
    );

    always_comb begin
        o_m_axis_tdata               = '0;
        o_m_axis_tdata[4*PIX_W-1:0]  = out_quad;
        o_m_axis_tdata[4*PIX_W +: CW] = out_col;
        o_m_axis_tdata[4*PIX_W+CW +: RW] = out_row;
    end

endmodule

// File: src/hpi_checker.sv
// Port-level checks on the half-pel interpolator output stream, bound to the top level.
`timescale 1ns / 1ps

module hpi_checker #(
    parameter int OUT_W = 56
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tlast,
    input logic             o_m_axis_tuser
);

    // frame end always closes a run
    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("frame end word without tlast");

    // the corner quad repeats one pixel four times
    a_frame_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            (o_m_axis_tdata[7:0] == o_m_axis_tdata[15:8]) &&
            (o_m_axis_tdata[7:0] == o_m_axis_tdata[23:16]) &&
            (o_m_axis_tdata[7:0] == o_m_axis_tdata[31:24]))
        else $error("frame end quad not flat");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output word changed");

endmodule

bind half_pel_image_interpolator_top hpi_checker #(
    .OUT_W (OUT_W)
) u_hpi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
